// File: rtl/core/twsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twsm_pkg
// Shared types and constants of the tilt window stability monitor.
// ----------------------------------------------------------------------------
package twsm_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 256;
    localparam int unsigned ONE_G_MG         = 1000;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_WINDOW_LEN   = 3'd0,
        REG_OMEGA_LIMIT  = 3'd1,
        REG_SHOCK_LIMIT  = 3'd2,
        REG_MOTION_MAX   = 3'd3,
        REG_SHOCK_MAX    = 3'd4,
        REG_SPREAD_MAX   = 3'd5,
        REG_MEAN_TOL     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [8:0]  window_len;
        logic [14:0] omega_limit;
        logic [13:0] shock_limit;
        logic [8:0]  motion_max;
        logic [8:0]  shock_max;
        logic [15:0] spread_max;
        logic [13:0] mean_tol;
    } t_cfg;

    // Classified command handed from the front to the back
    typedef struct packed {
        logic               op;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic [13:0]        accel;
        logic               gyro_mark;
        logic               shock_mark;
        logic               integrity_ok;
        logic               fault_active;
        logic               hold_active;
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/core/tilt_window_stability_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_window_stability_monitor
// Ring window of IMU samples with spike totals, centroid spread and a
// stability verdict per pushed sample.
// ----------------------------------------------------------------------------
// A push makes two memory read passes (one read port) over the N samples in the
// window and runs the bit-serial centroid divider twice, once per axis.
// A clear sweeps the auxiliary memory, one memory row per cycle. The back runs
// one item at a time; a two-entry queue in front of it takes the next items.
// Reset is synchronous, active low; after it a clearing pass zeroes the
// auxiliary window memory while no item is accepted. APB stays live.
// ----------------------------------------------------------------------------
module tilt_window_stability_monitor #(
    parameter int unsigned WINDOW_DEPTH = twsm_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // roll[15:0] pitch[31:16] omega[46:32] accel_mag_mg[60:47]
    // integrity_ok[61] fault_active[62] hold_active[63]
    input  wire logic [63:0] i_s_axis_tdata,
    // operation[0]
    input  wire logic        i_s_axis_tuser,
    // Result items
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // stable[0] integrity_fault[1] spread_sq[33:2] gyro_spikes[42:34]
    // shock_spikes[51:43] window_full[52] accel_mean_ok[53] zero[55:54]
    output logic [55:0]      o_m_axis_tdata,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import twsm_pkg::*;

    t_cfg     r_cfg;
    t_cmd     cmd;
    logic     cmd_valid;
    logic     cmd_pop;
    logic     init_busy;
    t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    // Register file: write on the APB access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_len  <= 9'd256;
            r_cfg.omega_limit <= 15'd50;
            r_cfg.shock_limit <= 14'd100;
            r_cfg.motion_max  <= 9'd0;
            r_cfg.shock_max   <= 9'd0;
            r_cfg.spread_max  <= 16'd100;
            r_cfg.mean_tol    <= 14'd50;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_WINDOW_LEN:  r_cfg.window_len  <= pwdata[8:0];
                REG_OMEGA_LIMIT: r_cfg.omega_limit <= pwdata[14:0];
                REG_SHOCK_LIMIT: r_cfg.shock_limit <= pwdata[13:0];
                REG_MOTION_MAX:  r_cfg.motion_max  <= pwdata[8:0];
                REG_SHOCK_MAX:   r_cfg.shock_max   <= pwdata[8:0];
                REG_SPREAD_MAX:  r_cfg.spread_max  <= pwdata[15:0];
                REG_MEAN_TOL:    r_cfg.mean_tol    <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register; hold zero for unused addresses
    always_comb begin
        case (reg_idx)
            REG_WINDOW_LEN:  prdata = 32'(r_cfg.window_len);
            REG_OMEGA_LIMIT: prdata = 32'(r_cfg.omega_limit);
            REG_SHOCK_LIMIT: prdata = 32'(r_cfg.shock_limit);
            REG_MOTION_MAX:  prdata = 32'(r_cfg.motion_max);
            REG_SHOCK_MAX:   prdata = 32'(r_cfg.shock_max);
            REG_SPREAD_MAX:  prdata = 32'(r_cfg.spread_max);
            REG_MEAN_TOL:    prdata = 32'(r_cfg.mean_tol);
            default:         prdata = '0;
        endcase
    end

    // Front: accept and classify each item, queue it
    twsm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_user      (i_s_axis_tuser),
        .i_init_busy (init_busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: run each command over the window, register the result
    twsm_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_init_busy (init_busy),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/core/twsm_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twsm_cmd_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module twsm_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire twsm_pkg::t_cmd i_data,
    output logic                o_full,
    output logic                o_valid,
    output twsm_pkg::t_cmd      o_data,
    input  wire logic           i_pop
);
    import twsm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

// File: rtl/core/twsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twsm_front
// Accept items, mark gyro and shock spikes, queue commands for the back.
// ----------------------------------------------------------------------------
module twsm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire twsm_pkg::t_cfg i_cfg,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [63:0]    i_data,
    input  wire logic           i_user,
    input  wire logic           i_init_busy,
    output logic                o_cmd_valid,
    output twsm_pkg::t_cmd      o_cmd,
    input  wire logic           i_cmd_pop
);
    import twsm_pkg::*;

    t_cmd        cmd;
    logic        full;
    logic [13:0] dev;

    always_comb begin
        cmd.op           = i_user;
        cmd.roll         = signed'(i_data[15:0]);
        cmd.pitch        = signed'(i_data[31:16]);
        cmd.accel        = i_data[60:47];
        cmd.integrity_ok = i_data[61];
        cmd.fault_active = i_data[62];
        cmd.hold_active  = i_data[63];
        cmd.gyro_mark    = (i_data[46:32] > i_cfg.omega_limit);
        // Deviation from 1 g in milli-g
        dev = (cmd.accel >= 14'(ONE_G_MG)) ? cmd.accel - 14'(ONE_G_MG)
                                            : 14'(ONE_G_MG) - cmd.accel;
        cmd.shock_mark   = (dev > i_cfg.shock_limit);
    end

    assign o_ready = !full && !i_init_busy;

    twsm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && o_ready),
        .i_data  (cmd),
        .o_full  (full),
        .o_valid (o_cmd_valid),
        .o_data  (o_cmd),
        .i_pop   (i_cmd_pop)
    );

endmodule
`default_nettype wire

// File: rtl/core/twsm_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twsm_divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module twsm_divider #(
    parameter int unsigned DW = 25,
    parameter int unsigned VW = 9
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [DW-1:0] i_dividend,
    input  wire logic [VW-1:0]        i_divisor,
    output logic                      o_done,
    output logic signed [DW-1:0]      o_quot
);
    localparam int unsigned NW = $clog2(DW + 1);

    logic          r_busy;
    logic [NW-1:0] r_cnt;
    logic [DW-1:0] r_mag;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic          r_neg;
    logic [VW:0]   rem_sh;
    logic          q_bit;

    always_comb begin
        rem_sh = {r_rem, r_mag[DW-1]};
        q_bit  = (rem_sh >= {1'b0, r_div});
    end

    assign o_quot = r_neg ? -signed'(r_mag) : signed'(r_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[DW-1];
        end else if (r_busy) begin
            r_rem <= q_bit ? VW'(rem_sh - {1'b0, r_div}) : VW'(rem_sh);
            r_mag <= {r_mag[DW-2:0], q_bit};
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/twsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twsm_back
// Window engine: ring memories, spike totals, centroid and spread passes,
// verdict and result register.
// ----------------------------------------------------------------------------
module twsm_back #(
    parameter int unsigned WINDOW_DEPTH = twsm_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire twsm_pkg::t_cfg i_cfg,
    input  wire logic           i_cmd_valid,
    input  wire twsm_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                o_init_busy,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [55:0]         o_data
);
    import twsm_pkg::*;

    localparam int unsigned AW  = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned WW  = (CW > 9) ? CW : 9;
    localparam int unsigned SW  = 16 + CW;
    localparam int unsigned ASW = 14 + CW;

    typedef enum logic [10:0] {
        S_INIT  = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_CLR   = 11'b000_0000_0100,
        S_RDOLD = 11'b000_0000_1000,
        S_UPD   = 11'b000_0001_0000,
        S_SUM   = 11'b000_0010_0000,
        S_DIVR  = 11'b000_0100_0000,
        S_DIVP  = 11'b000_1000_0000,
        S_MAX   = 11'b001_0000_0000,
        S_FIN1  = 11'b010_0000_0000,
        S_FIN2  = 11'b100_0000_0000
    } t_state;

    t_state r_state;

    // Window memories
    logic [31:0] r_tilt_mem [WINDOW_DEPTH];
    logic [15:0] r_aux_mem  [WINDOW_DEPTH];
    logic [31:0] r_tilt_q;
    logic [15:0] r_aux_q;

    // Control
    logic [AW-1:0] r_wpos;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_gtot;
    logic [CW-1:0] r_stot;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_left;
    logic [2:0]    r_v;
    logic          r_div_start;

    // Datapath
    t_cmd               r_cmd;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_oldest;
    logic signed [SW-1:0] r_sum_r;
    logic signed [SW-1:0] r_sum_p;
    logic [ASW-1:0]     r_sum_a;
    logic signed [16:0] r_mean_r;
    logic signed [16:0] r_mean_p;
    logic signed [17:0] r_dr;
    logic signed [17:0] r_dp;
    logic [31:0]        r_sqr;
    logic [31:0]        r_sqp;
    logic [32:0]        r_max;
    logic [31:0]        r_lim;
    logic [ASW-1:0]     r_tolw;
    logic [ASW-1:0]     r_onegw;

    logic [WW-1:0] wl;
    logic [CW-1:0] ws;
    logic [AW-1:0] slot;
    logic [AW-1:0] n_wpos;
    logic [CW-1:0] n_fill;
    logic [CW-1:0] n_count;
    logic [CW:0]   old_t;
    logic [AW-1:0] n_oldest;
    logic [AW-1:0] n_idx_inc;
    logic          issue;
    logic          sweep_end;
    logic          old_g;
    logic          old_s;
    logic [CW-1:0] n_gtot;
    logic [CW-1:0] n_stot;
    logic          full;
    logic [ASW-1:0] adiff;
    logic          mean_ok;
    logic          stable;
    logic          div_done;
    logic signed [SW-1:0] div_quot;
    logic [15:0]   aux_wdata;
    logic          out_free;

    always_comb begin
        wl = WW'(i_cfg.window_len);
        if (wl < WW'(2))                     ws = CW'(2);
        else if (wl > WW'(WINDOW_DEPTH))     ws = CW'(WINDOW_DEPTH);
        else                                 ws = CW'(wl);

        slot     = (CW'(r_wpos) < ws) ? r_wpos : '0;
        n_wpos   = (CW'(slot) + 1'b1 == ws) ? '0 : slot + 1'b1;
        n_fill   = (r_fill < ws) ? r_fill + 1'b1 : r_fill;
        n_count  = (n_fill < ws) ? n_fill : ws;
        old_t    = {1'b0, CW'(n_wpos)} + {1'b0, ws} - {1'b0, n_count};
        n_oldest = (old_t >= {1'b0, ws}) ? AW'(old_t - {1'b0, ws}) : AW'(old_t);
        n_idx_inc = (CW'(r_idx) + 1'b1 == ws) ? '0 : r_idx + 1'b1;

        issue     = (r_left != '0);
        sweep_end = (r_idx == AW'(WINDOW_DEPTH - 1));

        old_g  = r_aux_q[14];
        old_s  = r_aux_q[15];
        n_gtot = r_gtot - CW'(old_g) + CW'(r_cmd.gyro_mark);
        n_stot = r_stot - CW'(old_s) + CW'(r_cmd.shock_mark);

        aux_wdata = (r_state == S_UPD) ?
                    {r_cmd.shock_mark, r_cmd.gyro_mark, r_cmd.accel} : '0;

        full    = (r_fill >= ws);
        adiff   = (r_sum_a >= r_onegw) ? r_sum_a - r_onegw : r_onegw - r_sum_a;
        mean_ok = full && (adiff < r_tolw);
        stable  = r_cmd.integrity_ok && !r_cmd.fault_active && !r_cmd.hold_active &&
                  full &&
                  (WW'(r_gtot) <= WW'(i_cfg.motion_max)) &&
                  (WW'(r_stot) <= WW'(i_cfg.shock_max)) &&
                  (r_max <= {1'b0, r_lim});
        out_free = !o_valid || i_ready;
    end

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_init_busy = (r_state == S_INIT);

    twsm_divider #(
        .DW (SW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend ((r_state == S_DIVP) ? r_sum_p : r_sum_r),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Memories: one write port, one registered read port at r_idx
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD)
            r_tilt_mem[r_idx] <= {r_cmd.pitch, r_cmd.roll};
        if (r_state == S_UPD || r_state == S_INIT || r_state == S_CLR)
            r_aux_mem[r_idx] <= aux_wdata;
        r_tilt_q <= r_tilt_mem[r_idx];
        r_aux_q  <= r_aux_mem[r_idx];
    end

    // Control path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_gtot      <= '0;
            r_stot      <= '0;
            r_idx       <= '0;
            r_left      <= '0;
            r_v         <= '0;
            r_div_start <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_INIT, S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (sweep_end) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.op == OP_CLEAR) begin
                            r_wpos  <= '0;
                            r_fill  <= '0;
                            r_gtot  <= '0;
                            r_stot  <= '0;
                            r_idx   <= '0;
                            r_state <= S_CLR;
                        end else begin
                            r_idx   <= slot;
                            r_state <= S_RDOLD;
                        end
                    end
                end
                S_RDOLD: r_state <= S_UPD;
                S_UPD: begin
                    r_gtot <= n_gtot;
                    r_stot <= n_stot;
                    r_wpos <= n_wpos;
                    r_fill <= n_fill;
                    r_v    <= '0;
                    if (n_count < CW'(2)) begin
                        r_state <= S_FIN1;
                    end else begin
                        r_idx   <= n_oldest;
                        r_left  <= n_count;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (issue) begin
                        r_idx  <= n_idx_inc;
                        r_left <= r_left - 1'b1;
                    end
                    r_v <= {2'b00, issue};
                    if (!issue && !r_v[0]) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVR;
                    end
                end
                S_DIVR: begin
                    if (div_done) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVP;
                    end
                end
                S_DIVP: begin
                    if (div_done) begin
                        r_idx   <= r_oldest;
                        r_left  <= r_count;
                        r_v     <= '0;
                        r_state <= S_MAX;
                    end
                end
                S_MAX: begin
                    if (issue) begin
                        r_idx  <= n_idx_inc;
                        r_left <= r_left - 1'b1;
                    end
                    r_v <= {r_v[1:0], issue};
                    if (!issue && r_v == 3'b000) r_state <= S_FIN1;
                end
                S_FIN1: r_state <= S_FIN2;
                S_FIN2: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Data path
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) r_cmd <= i_cmd;
            end
            S_UPD: begin
                r_count  <= n_count;
                r_oldest <= n_oldest;
                r_sum_r  <= '0;
                r_sum_p  <= '0;
                r_sum_a  <= '0;
                r_max    <= '0;
            end
            S_SUM: begin
                if (r_v[0]) begin
                    r_sum_r <= r_sum_r + SW'(signed'(r_tilt_q[15:0]));
                    r_sum_p <= r_sum_p + SW'(signed'(r_tilt_q[31:16]));
                    r_sum_a <= r_sum_a + ASW'(r_aux_q[13:0]);
                end
            end
            S_DIVR: begin
                if (div_done) r_mean_r <= 17'(div_quot);
            end
            S_DIVP: begin
                if (div_done) r_mean_p <= 17'(div_quot);
            end
            S_MAX: begin
                // Stage 1: distance from centroid
                if (r_v[0]) begin
                    r_dr <= 18'(signed'(r_tilt_q[15:0])) - 18'(r_mean_r);
                    r_dp <= 18'(signed'(r_tilt_q[31:16])) - 18'(r_mean_p);
                end
                // Stage 2: square each axis
                if (r_v[1]) begin
                    r_sqr <= 32'(r_dr * r_dr);
                    r_sqp <= 32'(r_dp * r_dp);
                end
                // Stage 3: add and keep the maximum
                if (r_v[2]) begin
                    if ({1'b0, r_sqr} + {1'b0, r_sqp} > r_max)
                        r_max <= {1'b0, r_sqr} + {1'b0, r_sqp};
                end
            end
            S_FIN1: begin
                r_lim   <= i_cfg.spread_max * i_cfg.spread_max;
                r_tolw  <= ASW'(i_cfg.mean_tol * ws);
                r_onegw <= ASW'(10'(ONE_G_MG) * ws);
            end
            S_FIN2: begin
                if (out_free) begin
                    o_data <= {2'b00, mean_ok, full,
                               9'(r_stot), 9'(r_gtot),
                               (r_max[32] ? 32'hFFFF_FFFF : r_max[31:0]),
                               !r_cmd.integrity_ok, stable};
                end
            end
            default: ;
        endcase
    end

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_spike_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gtot <= CW'(WINDOW_DEPTH)) && (r_stot <= CW'(WINDOW_DEPTH)))
        else $error("spike total beyond window depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_fill != '0))
        else $error("window empty after a push");

    a_pop_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == S_CLR || r_state == S_RDOLD))
        else $error("popped command not dispatched");

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tilt window stability monitor: a directed
// table of pushes and clears, then random sample streams under several
// window settings, each result checked against an in-bench window model.
// ----------------------------------------------------------------------------
module tb;
    import twsm_pkg::*;

    localparam int DEPTH = 256;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        hold;
        logic        fault;
        logic        integ;
        logic [13:0] accel;
        logic [14:0] omega;
        logic [15:0] pitch;
        logic [15:0] roll;
    } t_sample;

    typedef struct packed {
        logic [1:0]  pad;
        logic        mean_ok;
        logic        full;
        logic [8:0]  shock_cnt;
        logic [8:0]  gyro_cnt;
        logic [31:0] spread;
        logic        ifault;
        logic        stable;
    } t_verdict;

    // Directed row: operation, sample, and an optional typed-in answer
    typedef struct {
        logic     op;
        t_sample  smp;
        bit       known;
        t_verdict ans;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    wire         s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    wire         m_tvalid;
    logic        m_tready;
    wire  [55:0] m_tdata;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    tilt_window_stability_monitor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Window model state and its register copy
    logic signed [15:0] mdl_roll  [DEPTH];
    logic signed [15:0] mdl_pitch [DEPTH];
    int unsigned        mdl_accel [DEPTH];
    bit                 mdl_gmark [DEPTH];
    bit                 mdl_smark [DEPTH];
    int unsigned mdl_wpos, mdl_fill, mdl_gtot, mdl_stot;
    int unsigned reg_wlen, reg_omega, reg_shock, reg_gmax, reg_smax, reg_spread, reg_tol;

    t_verdict pending_verdicts[$];
    int  errors = 0;
    int  results_seen = 0;
    int  pushes = 0, clears = 0;
    longint cycles = 0;
    bit  long_stall_req = 0;
    bit  gaps_on = 1;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, pending_verdicts.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned eff_window();
        if (reg_wlen < 2) return 2;
        if (reg_wlen > DEPTH) return DEPTH;
        return reg_wlen;
    endfunction

    task automatic window_clear();
        mdl_wpos = 0; mdl_fill = 0; mdl_gtot = 0; mdl_stot = 0;
        for (int k = 0; k < DEPTH; k++) begin
            mdl_accel[k] = 0; mdl_gmark[k] = 0; mdl_smark[k] = 0;
        end
    endtask

    // Push a sample into the model window and return the verdict it yields
    function automatic t_verdict window_push(t_sample s);
        int unsigned ws, slot, cnt, oldest, k, dev;
        longint sr, sp, mr, mp, dr, dp, asum, adiff;
        longint unsigned d, mx, lim;
        bit full, mean_ok;
        t_verdict v;
        ws = eff_window();
        slot = (mdl_wpos < ws) ? mdl_wpos : 0;
        mdl_roll[slot]  = s.roll;
        mdl_pitch[slot] = s.pitch;
        mdl_accel[slot] = s.accel;
        if (mdl_gmark[slot]) mdl_gtot--;
        mdl_gmark[slot] = (s.omega > reg_omega);
        mdl_gtot += mdl_gmark[slot];
        dev = (s.accel >= ONE_G_MG) ? s.accel - ONE_G_MG : ONE_G_MG - s.accel;
        if (mdl_smark[slot]) mdl_stot--;
        mdl_smark[slot] = (dev > reg_shock);
        mdl_stot += mdl_smark[slot];
        mdl_wpos = (slot + 1) % ws;
        if (mdl_fill < ws) mdl_fill++;
        full = (mdl_fill >= ws);

        cnt = (mdl_fill < ws) ? mdl_fill : ws;
        mx = 0;
        if (cnt >= 2) begin
            oldest = (mdl_wpos + ws - cnt) % ws;
            sr = 0; sp = 0;
            for (int i = 0; i < cnt; i++) begin
                k = (oldest + i) % ws;
                sr += mdl_roll[k]; sp += mdl_pitch[k];
            end
            mr = sr / longint'(cnt);   // SV division truncates toward zero
            mp = sp / longint'(cnt);
            for (int i = 0; i < cnt; i++) begin
                k = (oldest + i) % ws;
                dr = longint'(mdl_roll[k]) - mr;
                dp = longint'(mdl_pitch[k]) - mp;
                d = dr * dr + dp * dp;
                if (d > mx) mx = d;
            end
        end

        mean_ok = 0;
        if (full) begin
            asum = 0;
            for (int i = 0; i < ws; i++) asum += mdl_accel[i];
            adiff = asum - longint'(ONE_G_MG) * ws;
            if (adiff < 0) adiff = -adiff;
            mean_ok = adiff < longint'(reg_tol) * ws;
        end
        lim = longint'(reg_spread) * reg_spread;

        v = '0;
        v.ifault = !s.integ;
        v.stable = s.integ && !s.fault && !s.hold && full && mdl_gtot <= reg_gmax
                   && mdl_stot <= reg_smax && mx <= lim;
        v.spread = (mx > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mx[31:0];
        v.gyro_cnt = mdl_gtot[8:0];
        v.shock_cnt = mdl_stot[8:0];
        v.full = full;
        v.mean_ok = mean_ok;
        return v;
    endfunction

    // Drive one register write in a setup and an access cycle, then read it back
    task automatic reg_write(t_reg_idx idx, int unsigned val);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 0;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        if (prdata !== val) begin
            $display("%0t: register %s readback expected %0d actual %0d",
                     $time, idx.name(), val, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel = 0; penable = 0;
        case (idx)
            REG_WINDOW_LEN:  reg_wlen   = val;
            REG_OMEGA_LIMIT: reg_omega  = val;
            REG_SHOCK_LIMIT: reg_shock  = val;
            REG_MOTION_MAX:  reg_gmax   = val;
            REG_SHOCK_MAX:   reg_smax   = val;
            REG_SPREAD_MAX:  reg_spread = val;
            REG_MEAN_TOL:    reg_tol    = val;
            default: ;
        endcase
    endtask

    task automatic settings(int unsigned wl, int unsigned om, int unsigned sh, int unsigned gm,
                            int unsigned sm, int unsigned sp, int unsigned tl);
        reg_write(REG_WINDOW_LEN, wl);
        reg_write(REG_OMEGA_LIMIT, om);
        reg_write(REG_SHOCK_LIMIT, sh);
        reg_write(REG_MOTION_MAX, gm);
        reg_write(REG_SHOCK_MAX, sm);
        reg_write(REG_SPREAD_MAX, sp);
        reg_write(REG_MEAN_TOL, tl);
    endtask

    // Hand one item to the block; hold valid until accepted, then maybe idle
    task automatic send_item(logic op, t_sample s, bit known, t_verdict ans);
        t_verdict v;
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= s;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (op == OP_CLEAR) begin
            window_clear();
            clears++;
        end else begin
            v = window_push(s);
            if (known && v !== ans) begin
                $display("%0t: directed row expected %h model %h", $time, ans, v);
                errors++;
            end
            pending_verdicts.push_back(v);
            pushes++;
        end
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic idle_sender();
        s_tvalid <= 0;
    endtask

    // Wait until every result is back, then let a clear still in flight finish
    task automatic drain();
        idle_sender();
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (DEPTH + 40) @(negedge i_clk);
    endtask

    function automatic t_sample rand_sample(int mode);
        t_sample s;
        s.roll  = 16'($signed($urandom_range(0, 36000)) - 18000);
        s.pitch = 16'($signed($urandom_range(0, 36000)) - 18000);
        if (mode == 1) begin
            // quiet platform: small tilt scatter, near 1 g, low rate
            s.roll  = 16'($signed($urandom_range(0, 200)) - 100 + 500);
            s.pitch = 16'($signed($urandom_range(0, 200)) - 100 - 700);
            s.accel = 14'($urandom_range(960, 1040));
            s.omega = 15'($urandom_range(0, 60));
            s.integ = ($urandom_range(0, 15) != 0);
            s.fault = ($urandom_range(0, 15) == 0);
            s.hold  = ($urandom_range(0, 15) == 0);
        end else begin
            s.accel = 14'($urandom_range(0, 16000));
            s.omega = 15'($urandom_range(0, 20000));
            s.integ = $urandom_range(0, 1);
            s.fault = $urandom_range(0, 1);
            s.hold  = $urandom_range(0, 1);
        end
        return s;
    endfunction

    // Receiver: stall on its own pattern, or hold off for a long stretch on request
    initial begin
        int phase;
        m_tready = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (long_stall_req) begin
                m_tready <= 0;
                repeat (4000) @(negedge i_clk);
                long_stall_req = 0;
            end else if ((phase % 97) < 40) begin
                m_tready <= 1;
            end else begin
                m_tready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                results_seen++;
                if (got.stable !== want.stable || got.ifault !== want.ifault ||
                    got.spread !== want.spread || got.gyro_cnt !== want.gyro_cnt ||
                    got.shock_cnt !== want.shock_cnt || got.full !== want.full ||
                    got.mean_ok !== want.mean_ok || got.pad !== 2'b00) begin
                    $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_verdict z;
        t_sample s;
        int mode;
        i_rst_n = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        reg_wlen = 256; reg_omega = 50; reg_shock = 100; reg_gmax = 0; reg_smax = 0;
        reg_spread = 100; reg_tol = 50;
        for (int k = 0; k < DEPTH; k++) begin
            mdl_roll[k] = 0; mdl_pitch[k] = 0;
        end
        window_clear();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: window of 2, then extremes and clears
        settings(2, 50, 100, 0, 0, 100, 50);
        z = '0;
        // first push after reset: one sample, no spread, not full
        r.op = OP_PUSH; r.smp = '{hold:0, fault:0, integ:1, accel:1000, omega:0,
                                  pitch:0, roll:0};
        r.known = 1; r.ans = z; rows.push_back(r);
        // second identical sample fills the window: stable, mean exact
        r.ans = z; r.ans.stable = 1; r.ans.full = 1; r.ans.mean_ok = 1; rows.push_back(r);
        // integrity failure flags the fault
        r.smp.integ = 0; r.ans = z; r.ans.ifault = 1; r.ans.full = 1; r.ans.mean_ok = 1;
        rows.push_back(r);
        r.smp.integ = 1; r.smp.fault = 1; r.known = 0; rows.push_back(r);
        r.smp.fault = 0; r.smp.hold = 1; rows.push_back(r);
        r.smp.hold = 0;
        r.op = OP_CLEAR; rows.push_back(r);
        // opposite tilt extremes give a large spread
        r.op = OP_PUSH; r.smp.roll = 16'sd18000; r.smp.pitch = 16'sd18000;
        r.smp.accel = 14'd16000; r.smp.omega = 15'd20000; rows.push_back(r);
        r.smp.roll = -16'sd18000; r.smp.pitch = -16'sd18000; r.smp.accel = 0; rows.push_back(r);
        r.smp.roll = 16'h7FFF; r.smp.pitch = 16'h8000; r.smp.accel = 14'h3FFF;
        r.smp.omega = 15'h7FFF; rows.push_back(r);
        r.smp.roll = 16'h8000; r.smp.pitch = 16'h7FFF; r.smp.accel = 0; r.smp.omega = 0;
        rows.push_back(r);
        r.smp.roll = -16'sd3; r.smp.pitch = 16'sd2; r.smp.accel = 1100; r.smp.omega = 50;
        rows.push_back(r);
        r.smp.roll = 16'sd0; r.smp.pitch = -16'sd1; r.smp.accel = 899; r.smp.omega = 51;
        rows.push_back(r);
        r.op = OP_CLEAR; rows.push_back(r);
        foreach (rows[i]) send_item(rows[i].op, rows[i].smp, rows[i].known, rows[i].ans);
        drain();

        // Random phases over several settings, extremes included
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: settings(2, 0, 0, 256, 256, 36000, 16000);
                1: settings(5, 50, 100, 1, 1, 150, 50);
                2: settings(0, 20000, 16000, 0, 0, 0, 0);
                3: settings(16, 60, 40, 2, 3, 120, 20);
                4: settings(256, 50, 100, 0, 0, 100, 50);
                5: settings(511, 30, 60, 5, 5, 200, 30);
                default: settings(7, 40, 30, 1, 2, 110, 25);
            endcase
            send_item(OP_CLEAR, '0, 0, z);
            gaps_on = (ph != 3);
            if (ph == 1) long_stall_req = 1;
            for (int n = 0; n < ((ph >= 4 && ph <= 5) ? 50 : 80); n++) begin
                mode = ($urandom_range(0, 9) < 7) ? 1 : 0;
                s = rand_sample(mode);
                if ($urandom_range(0, 40) == 0) send_item(OP_CLEAR, s, 0, z);
                else send_item(OP_PUSH, s, 0, z);
            end
            drain();
        end

        $display("Covered %0d pushes and %0d clears over eight register settings;",
                 pushes, clears);
        $display("%0d results checked, window sizes 2 to 256 including out-of-range values.",
                 results_seen);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
